// ===== rtl/lbbs_pkg.sv =====
// Shared types and constants for the LED blink and breath sequencer.
// No dependencies; used by every other file in rtl/.
`timescale 1ns / 1ps

package lbbs_pkg;

    // Command codes carried on the input tuser
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_SET    = 3'd1;
    localparam logic [2:0] ACT_BLINK  = 3'd2;
    localparam logic [2:0] ACT_BREATH = 3'd3;
    localparam logic [2:0] ACT_STOP   = 3'd4;

    // Engine modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_BLINK  = 2'd1;
    localparam logic [1:0] MODE_BREATH = 2'd2;

    // Breath ramp limits; LEVEL_FULL is also the scaling divisor
    localparam logic [6:0] LEVEL_FULL   = 7'd127;
    localparam logic [6:0] LEVEL_TOP_UP = 7'd126;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [15:0] step_time;
        logic [7:0]  repeat_count;
    } cmd_t;

    typedef struct packed {
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic       pattern_busy;
    } result_t;

endpackage

// ===== rtl/led_blink_breath_sequencer.sv =====
// Top level of the LED blink and breath sequencer: input register, engine, output register.
// Depends on lbbs_pkg, lbbs_engine and lbbs_scaler.
`timescale 1ns / 1ps

// Usage
//   Slave channel s_axis_*: one command beat per cycle when ready. tuser carries
//   the action (tick, set colour, start blink, start breath, stop); tdata carries
//   the colour, step time and repeat count, read only by set colour and the two starts.
//   Master channel m_axis_*: exactly one result beat for every command beat, in
//   order, giving the colour shown after that command and the pattern-busy flag.
// Pipeline and throughput
//   A beat accepted into the input register is processed by the engine and its
//   result is captured in the output register, from which it is taken on the
//   master channel. One beat per cycle is sustained while m_axis_tready is high;
//   the engine's single pass (tick counter compare, breath step and the
//   divide-by-127 scaler) sets it.
// Reset
//   rst_n clears the valid flags of both pipeline registers and the engine: idle,
//   LEDs dark, step time one, counters zero. No result beats are pending after reset.
// Stalls
//   While m_axis_tready is low the result is held in the output register and
//   the engine does not advance; one more beat is still taken into the input
//   register, after which s_axis_tready drops until the output drains.

module led_blink_breath_sequencer
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // red_in[7:0], green_in[15:8], blue_in[23:16], step_time[39:24],
    // repeat_count[47:40]
    input  logic [lbbs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // action[2:0]
    input  logic [lbbs_pkg::IN_TUSER_W-1:0] s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // led_red[7:0], led_green[15:8], led_blue[23:16], pattern_busy[24], zero[31:25]
    output logic [lbbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic              in_valid_reg,  in_valid_next;
    lbbs_pkg::cmd_t    in_cmd_reg;
    logic              out_valid_reg, out_valid_next;
    lbbs_pkg::result_t out_res_reg;

    lbbs_pkg::result_t eng_result;
    logic              advance;
    logic              fire;
    logic              s_accept;

    // Advance the pipe whenever the output register is empty or being drained
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the command beat; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg.action       <= s_axis_tuser[2:0];
            in_cmd_reg.red_in       <= s_axis_tdata[7:0];
            in_cmd_reg.green_in     <= s_axis_tdata[15:8];
            in_cmd_reg.blue_in      <= s_axis_tdata[23:16];
            in_cmd_reg.step_time    <= s_axis_tdata[39:24];
            in_cmd_reg.repeat_count <= s_axis_tdata[47:40];
        end
        if (fire)
        begin
            out_res_reg <= eng_result;
        end
    end

    lbbs_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cmd    (in_cmd_reg),
        .result (eng_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.pattern_busy, out_res_reg.led_blue,
                            out_res_reg.led_green, out_res_reg.led_red};

endmodule

// ===== rtl/lbbs_scaler.sv =====
// One colour channel scaled by a breath level: chan * level / 127, truncated.
// Depends on lbbs_pkg for the full-scale level.
`timescale 1ns / 1ps

module lbbs_scaler
(
    input  logic [7:0] chan,
    input  logic [6:0] level,
    output logic [7:0] scaled
);

    logic [15:0] prod;
    logic [15:0] est_sum;
    logic [8:0]  q_est;
    logic [15:0] rem;

    // Divide by 127 as (x + x/128 + 1) / 128; the estimate is at most one low
    assign prod    = {8'd0, chan} * {9'd0, level};
    assign est_sum = prod + {7'd0, prod[15:7]} + 16'd1;
    assign q_est   = est_sum[15:7];
    assign rem     = prod - {q_est, 7'd0} + {7'd0, q_est};

    always_comb
    begin
        if (rem >= {9'd0, lbbs_pkg::LEVEL_FULL})
        begin
            scaled = q_est[7:0] + 8'd1;
        end
        else
        begin
            scaled = q_est[7:0];
        end
    end

endmodule

// ===== rtl/lbbs_engine.sv =====
// Pattern state and next-state logic of the LED sequencer.
// Depends on lbbs_pkg and lbbs_scaler.
`timescale 1ns / 1ps

module lbbs_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lbbs_pkg::cmd_t   cmd,
    output lbbs_pkg::result_t result
);

    logic [1:0]  mode_reg,        mode_next;
    logic [23:0] base_reg,        base_next;
    logic [15:0] hold_reg,        hold_next;
    logic [7:0]  target_reg,      target_next;
    logic [7:0]  done_reg,        done_next;
    logic [15:0] tick_reg,        tick_next;
    logic [6:0]  level_reg,       level_next;
    logic        ramp_down_reg,   ramp_down_next;
    logic        off_phase_reg,   off_phase_next;
    logic [23:0] shown_reg,       shown_next;

    logic [6:0]  level_step;
    logic        ramp_step;
    logic [23:0] scaled;
    logic [15:0] tick_inc;
    logic [7:0]  done_inc;
    logic        count_met;
    logic [23:0] cmd_color;

    // Level the breath ramp moves to on its next step
    always_comb
    begin
        level_step = level_reg;
        ramp_step  = ramp_down_reg;
        if (!ramp_down_reg)
        begin
            if (level_reg < lbbs_pkg::LEVEL_TOP_UP)
            begin
                level_step = level_reg + 7'd1;
            end
            else
            begin
                level_step = lbbs_pkg::LEVEL_FULL;
                ramp_step  = 1'b1;
            end
        end
        else if (level_reg > 7'd1)
        begin
            level_step = level_reg - 7'd1;
        end
        else
        begin
            level_step = 7'd0;
            ramp_step  = 1'b0;
        end
    end

    genvar ch;
    generate
        for (ch = 0; ch < 3; ch++)
        begin : g_chan
            lbbs_scaler u_scaler
            (
                .chan   (base_reg[ch*8 +: 8]),
                .level  (level_step),
                .scaled (scaled[ch*8 +: 8])
            );
        end
    endgenerate

    assign tick_inc  = tick_reg + 16'd1;
    assign done_inc  = done_reg + 8'd1;
    assign count_met = (target_reg != 8'd0) && (done_inc >= target_reg);
    assign cmd_color = {cmd.red_in, cmd.green_in, cmd.blue_in};

    always_comb
    begin
        mode_next      = mode_reg;
        base_next      = base_reg;
        hold_next      = hold_reg;
        target_next    = target_reg;
        done_next      = done_reg;
        tick_next      = tick_reg;
        level_next     = level_reg;
        ramp_down_next = ramp_down_reg;
        off_phase_next = off_phase_reg;
        shown_next     = shown_reg;

        case (cmd.action)
            lbbs_pkg::ACT_TICK:
            begin
                if (mode_reg != lbbs_pkg::MODE_IDLE)
                begin
                    if (tick_inc >= hold_reg)
                    begin
                        tick_next = 16'd0;
                        if (mode_reg == lbbs_pkg::MODE_BLINK)
                        begin
                            off_phase_next = !off_phase_reg;
                            if (!off_phase_reg)
                            begin
                                shown_next = 24'd0;
                            end
                            else
                            begin
                                if (target_reg != 8'd0)
                                begin
                                    done_next = done_inc;
                                end
                                if (count_met)
                                begin
                                    mode_next = lbbs_pkg::MODE_IDLE;
                                end
                                else
                                begin
                                    shown_next = base_reg;
                                end
                            end
                        end
                        else
                        begin
                            level_next     = level_step;
                            ramp_down_next = ramp_step;
                            // End of a breath cycle: ramp down passed level one
                            if (ramp_down_reg && level_reg <= 7'd1)
                            begin
                                if (target_reg != 8'd0)
                                begin
                                    done_next = done_inc;
                                end
                                if (count_met)
                                begin
                                    mode_next = lbbs_pkg::MODE_IDLE;
                                end
                                else
                                begin
                                    shown_next = scaled;
                                end
                            end
                            else
                            begin
                                shown_next = scaled;
                            end
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            lbbs_pkg::ACT_SET:
            begin
                if (mode_reg == lbbs_pkg::MODE_IDLE)
                begin
                    shown_next = cmd_color;
                end
            end
            lbbs_pkg::ACT_BLINK,
            lbbs_pkg::ACT_BREATH:
            begin
                mode_next      = (cmd.action == lbbs_pkg::ACT_BLINK) ?
                                 lbbs_pkg::MODE_BLINK : lbbs_pkg::MODE_BREATH;
                base_next      = cmd_color;
                hold_next      = (cmd.step_time == 16'd0) ? 16'd1 : cmd.step_time;
                target_next    = cmd.repeat_count;
                done_next      = 8'd0;
                tick_next      = 16'd0;
                level_next     = 7'd0;
                ramp_down_next = 1'b0;
                off_phase_next = 1'b0;
                // Breath opens at level zero, which is dark
                shown_next     = (cmd.action == lbbs_pkg::ACT_BLINK) ? cmd_color : 24'd0;
            end
            lbbs_pkg::ACT_STOP:
            begin
                mode_next  = lbbs_pkg::MODE_IDLE;
                shown_next = 24'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lbbs_pkg::MODE_IDLE;
            base_reg      <= 24'd0;
            hold_reg      <= 16'd1;
            target_reg    <= 8'd0;
            done_reg      <= 8'd0;
            tick_reg      <= 16'd0;
            level_reg     <= 7'd0;
            ramp_down_reg <= 1'b0;
            off_phase_reg <= 1'b0;
            shown_reg     <= 24'd0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            base_reg      <= base_next;
            hold_reg      <= hold_next;
            target_reg    <= target_next;
            done_reg      <= done_next;
            tick_reg      <= tick_next;
            level_reg     <= level_next;
            ramp_down_reg <= ramp_down_next;
            off_phase_reg <= off_phase_next;
            shown_reg     <= shown_next;
        end
    end

    assign result.led_red      = shown_next[23:16];
    assign result.led_green    = shown_next[15:8];
    assign result.led_blue     = shown_next[7:0];
    assign result.pattern_busy = (mode_next != lbbs_pkg::MODE_IDLE);

endmodule

// ===== rtl/lbbs_checker.sv =====
// Port-level checks for the LED sequencer, bound onto the top level.
// Depends on lbbs_pkg and led_blink_breath_sequencer.
`timescale 1ns / 1ps

module lbbs_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [lbbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result beat
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Back-pressure on the input only ever comes from a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled output");

    // A consumer that is always ready never holds up commands
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input not ready while output drains");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
        else $error("result padding bits not zero");

endmodule

bind led_blink_breath_sequencer lbbs_checker u_lbbs_checker (.*);
